### rtl/shp3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shp3_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 2048;
	localparam int unsigned QUEUE_DEPTH   = 2;

	localparam int unsigned PIX_W      = 8;
	localparam int unsigned WIDTH_W    = 12;
	localparam int unsigned HEIGHT_W   = 16;
	localparam int unsigned ROW_W      = HEIGHT_W + 1;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;

	localparam int unsigned WIDTH_RST  = 640;
	localparam int unsigned HEIGHT_RST = 480;
	localparam int unsigned WIDTH_MIN  = 3;
	localparam int unsigned HEIGHT_MIN = 3;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// what the front decided about one word
	typedef struct packed {
		logic touch;   // reads and writes the line store
		logic emit;    // produces an output word
		logic zero;    // border pixel, forced to 0
		logic last;    // last column of the row
		logic eof;     // last word of the output frame
	} shp3_cmd_t;

	localparam int unsigned CMD_W = $bits(shp3_cmd_t);

endpackage

`default_nettype wire

### rtl/sharpen_3x3_stream.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata: in_pixel; tuser: drain
// m_axis    out  m_axis_tvalid/tready       tdata: out_pixel; tlast: end_of_row;
//                                           tuser: end_of_frame
// cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// one pixel per clock sustained unless m_axis stalls; results are registered on m_axis
// the line store has one write and one read port, each used once per pixel
// reset clears counters, queue and pipeline; geometry returns to 640 x 480
// the line store is not cleared, rows are written before they are read
// a stalled m_axis fills the output register, stage two and the two-entry queue
// before s_axis_tready drops

module sharpen_3x3_stream #(
	parameter int unsigned MAX_WIDTH = shp3_pkg::MAX_WIDTH_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire  [7:0]                          s_axis_tdata,   // [7:0] in_pixel
	input  wire                                 s_axis_tuser,   // [0] drain
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	output logic [7:0]                          m_axis_tdata,   // [7:0] out_pixel
	output logic                                m_axis_tlast,   // end_of_row
	output logic                                m_axis_tuser,   // [0] end_of_frame
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [shp3_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [shp3_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import shp3_pkg::*;

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned QW = CW + PIX_W + CMD_W;

	logic             accept;
	logic             push;
	shp3_cmd_t        push_cmd;
	logic [PIX_W-1:0] push_pix;
	logic [CW-1:0]    push_col;

	logic             q_not_full;
	logic             head_valid;
	logic             pop;
	logic [QW-1:0]    head_data;
	shp3_cmd_t        head_cmd;
	logic [PIX_W-1:0] head_pix;
	logic [CW-1:0]    head_col;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = q_not_full;
	assign accept        = s_axis_tvalid && q_not_full;

	shp3_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.in_pixel  (s_axis_tdata),
		.drain     (s_axis_tuser),
		.push      (push),
		.push_cmd  (push_cmd),
		.push_pix  (push_pix),
		.push_col  (push_col)
	);

	shp3_queue #(
		.DATA_W (QW),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({push_col, push_pix, push_cmd}),
		.not_full   (q_not_full),
		.head_valid (head_valid),
		.pop        (pop),
		.head_data  (head_data)
	);

	assign head_cmd = head_data[CMD_W-1:0];
	assign head_pix = head_data[CMD_W+PIX_W-1:CMD_W];
	assign head_col = head_data[QW-1:CMD_W+PIX_W];

	shp3_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_cmd      (head_cmd),
		.head_pix      (head_pix),
		.head_col      (head_col),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire

### rtl/shp3_front.sv
`timescale 1ns / 1ps
`default_nettype none

module shp3_front #(
	parameter int unsigned MAX_WIDTH = shp3_pkg::MAX_WIDTH_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_valid,
	input  wire  [shp3_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [shp3_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire                                   accept,
	input  wire  [shp3_pkg::PIX_W-1:0]            in_pixel,
	input  wire                                   drain,
	output logic                                  push,
	output shp3_pkg::shp3_cmd_t                   push_cmd,
	output logic [shp3_pkg::PIX_W-1:0]            push_pix,
	output logic [$clog2(MAX_WIDTH)-1:0]          push_col
);
	import shp3_pkg::*;

	localparam int unsigned CW   = $clog2(MAX_WIDTH);
	localparam int unsigned WCMP = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
	localparam int unsigned WIDTH_RST_EFF = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

	logic [CW-1:0]       last_col_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [CW-1:0]       col_q;
	logic [ROW_W-1:0]    row_q;

	logic [WCMP-1:0]     w_ext;
	logic [CW-1:0]       last_col_new;
	logic [HEIGHT_W-1:0] height_new;
	logic                last_col;
	logic                drain_row;

	// clamp geometry on the way in
	always_comb begin
		w_ext = WCMP'(cfg_data[WIDTH_W-1:0]);
		priority if (w_ext < WCMP'(WIDTH_MIN)) begin
			last_col_new = CW'(WIDTH_MIN - 1);
		end else if (w_ext > WCMP'(MAX_WIDTH)) begin
			last_col_new = CW'(MAX_WIDTH - 1);
		end else begin
			last_col_new = CW'(w_ext - WCMP'(1));
		end
		if (cfg_data[HEIGHT_W-1:0] < HEIGHT_W'(HEIGHT_MIN)) begin
			height_new = HEIGHT_W'(HEIGHT_MIN);
		end else begin
			height_new = cfg_data[HEIGHT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= CW'(WIDTH_RST_EFF - 1);
			height_q   <= HEIGHT_W'(HEIGHT_RST);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  last_col_q <= last_col_new;
				REG_FRAME_HEIGHT: height_q   <= height_new;
				default: ;
			endcase
		end
	end

	assign last_col  = col_q >= last_col_q;
	assign drain_row = row_q >= {1'b0, height_q};

	// early drain words are dropped here
	assign push = accept && (drain_row || !drain);

	always_comb begin
		push_cmd.touch = !drain_row;
		push_cmd.emit  = drain_row || (row_q != '0);
		push_cmd.zero  = drain_row || (row_q == ROW_W'(1)) || (col_q == '0) || last_col;
		push_cmd.last  = last_col;
		push_cmd.eof   = drain_row && last_col;
	end

	assign push_pix = in_pixel;
	assign push_col = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= drain_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	a_drain_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(push && drain_row && last_col) |=> (col_q == '0 && row_q == '0))
		else $error("frame did not wrap after the drain row");

endmodule

`default_nettype wire

### rtl/shp3_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module shp3_queue #(
	parameter int unsigned DATA_W = 8,
	parameter int unsigned DEPTH  = shp3_pkg::QUEUE_DEPTH
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  wire  [DATA_W-1:0]  push_data,
	output logic               not_full,
	output logic               head_valid,
	input  wire                pop,
	output logic [DATA_W-1:0]  head_data
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned NW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [NW-1:0]     count_q;

	assign not_full   = count_q != NW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (not_full || pop))
		else $error("push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from an empty queue");

endmodule

`default_nettype wire

### rtl/shp3_back.sv
`timescale 1ns / 1ps
`default_nettype none

module shp3_back #(
	parameter int unsigned MAX_WIDTH = shp3_pkg::MAX_WIDTH_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   head_valid,
	input  shp3_pkg::shp3_cmd_t                   head_cmd,
	input  wire  [shp3_pkg::PIX_W-1:0]            head_pix,
	input  wire  [$clog2(MAX_WIDTH)-1:0]          head_col,
	output logic                                  pop,
	output logic                                  m_axis_tvalid,
	input  wire                                   m_axis_tready,
	output logic [shp3_pkg::PIX_W-1:0]            m_axis_tdata,
	output logic                                  m_axis_tlast,
	output logic                                  m_axis_tuser
);
	import shp3_pkg::*;

	localparam int unsigned CW = $clog2(MAX_WIDTH);

	// one entry per column: upper row in the high byte, middle row in the low byte
	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] line_rd_q;
	logic [PIX_W-1:0]   prev_mid_q;
	logic [CW-1:0]      rd_addr;

	logic               valid_s2;
	shp3_cmd_t          cmd_s2;
	logic [PIX_W-1:0]   pix_s2;
	logic [PIX_W-1:0]   centre_s2;
	logic [PIX_W-1:0]   left_s2;
	logic [PIX_W-1:0]   up_s2;

	logic               out_valid_q;
	logic [PIX_W-1:0]   out_pixel_q;
	logic               out_eor_q;
	logic               out_eof_q;

	logic               out_free;
	logic               move_s2;
	logic               free_s2;
	logic               touch;

	logic [PIX_W+2:0]   five_c;
	logic [PIX_W+1:0]   ring;
	logic signed [PIX_W+3:0] diff;
	logic [PIX_W-1:0]   sat;

	assign out_free = !out_valid_q || m_axis_tready;
	assign move_s2  = valid_s2 && (!cmd_s2.emit || out_free);
	assign free_s2  = !valid_s2 || move_s2;
	assign pop      = head_valid && free_s2;
	assign touch    = pop && head_cmd.touch;

	// fetch one column ahead: the next word's centre and up, and this word's right
	assign rd_addr = head_cmd.last ? '0 : head_col + CW'(1);

	always_ff @(posedge clk) begin
		if (touch) begin
			line_mem[head_col] <= {line_rd_q[PIX_W-1:0], head_pix};
			line_rd_q          <= line_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s2 <= head_cmd;
			pix_s2 <= head_pix;
		end
		if (touch) begin
			centre_s2  <= line_rd_q[PIX_W-1:0];
			up_s2      <= line_rd_q[2*PIX_W-1:PIX_W];
			left_s2    <= prev_mid_q;
			prev_mid_q <= line_rd_q[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= pop;
		end
	end

	// 5*centre - left - right - up - down
	always_comb begin
		five_c = {1'b0, centre_s2, 2'b00} + {3'b000, centre_s2};
		ring   = {2'b00, left_s2} + {2'b00, line_rd_q[PIX_W-1:0]}
		       + {2'b00, up_s2} + {2'b00, pix_s2};
		diff   = $signed({1'b0, five_c}) - $signed({2'b00, ring});
		priority if (diff < 0) begin
			sat = '0;
		end else if (diff > $signed((PIX_W+4)'(255))) begin
			sat = '1;
		end else begin
			sat = diff[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s2 && cmd_s2.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2 && cmd_s2.emit) begin
			out_pixel_q <= cmd_s2.zero ? '0 : sat;
			out_eor_q   <= cmd_s2.last;
			out_eof_q   <= cmd_s2.eof;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_pixel_q;
	assign m_axis_tlast  = out_eor_q;
	assign m_axis_tuser  = out_eof_q;

	a_out_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(move_s2 && cmd_s2.emit))
		else $error("output word appeared without a stage two transfer");

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import shp3_pkg::*;

	localparam int unsigned LINE_MAX      = MAX_WIDTH_DEF;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned MAX_PRINTS    = 40;
	localparam int          CENTRE_GAIN   = 5;
	localparam int          PIX_MAX       = 255;

	typedef struct {
		logic [PIX_W-1:0] pix;
		logic             drain;
		logic             hold;   // hold back until the output side has emptied
	} pix_word_t;

	typedef struct {
		logic [PIX_W-1:0] pix;
		logic             eor;
		logic             eof;
	} sharp_word_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata  = '0;   // [7:0] in_pixel
	logic                  s_axis_tuser  = 1'b0; // [0] drain
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [7:0]            m_axis_tdata;         // [7:0] out_pixel
	logic                  m_axis_tlast;         // end_of_row
	logic                  m_axis_tuser;         // [0] end_of_frame
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = REG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	sharpen_3x3_stream dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// sharpening predictor state
	logic [WIDTH_W-1:0]  geo_width  = WIDTH_W'(WIDTH_RST);
	logic [HEIGHT_W-1:0] geo_height = HEIGHT_W'(HEIGHT_RST);
	bit [PIX_W-1:0]      upper_line  [LINE_MAX];
	bit [PIX_W-1:0]      middle_line [LINE_MAX];
	int unsigned         col_pos = 0;
	int unsigned         row_pos = 0;
	bit [PIX_W-1:0]      win_left, win_centre, win_right;

	pix_word_t   pix_q[$];
	sharp_word_t sharp_q[$];
	pix_word_t   cur_word;
	sharp_word_t due_word;
	logic        s_went_in = 1'b0;
	int unsigned snd_idle  = 9;
	int unsigned rcv_idle  = 53;
	int unsigned mismatches = 0;
	int unsigned fed = 0;

	// first directed frame: saturation both ways
	logic [7:0] grid [16] = '{
		8'd0,   8'd0,   8'd255, 8'd9,
		8'd0,   8'd255, 8'd0,   8'd255,
		8'd128, 8'd60,  8'd50,  8'd7,
		8'd1,   8'd0,   8'd30,  8'd255
	};

	function automatic int unsigned eff_w(logic [WIDTH_W-1:0] raw);
		if (raw < WIDTH_MIN)
			return WIDTH_MIN;
		if (raw > LINE_MAX)
			return LINE_MAX;
		return raw;
	endfunction

	function automatic int unsigned eff_h(logic [HEIGHT_W-1:0] raw);
		return (raw < HEIGHT_MIN) ? HEIGHT_MIN : raw;
	endfunction

	function automatic void sharpen_predict(pix_word_t wd);
		int unsigned    w;
		int unsigned    h;
		logic           last_col;
		bit [PIX_W-1:0] old_mid;
		bit [PIX_W-1:0] up;
		int             acc;
		w = eff_w(geo_width);
		h = eff_h(geo_height);
		last_col = (col_pos >= w - 1);
		if (row_pos >= h) begin
			// flush row: bottom border, all zero
			sharp_q.push_back('{pix: '0, eor: last_col, eof: last_col});
			if (last_col) begin
				col_pos = 0;
				row_pos = 0;
			end else
				col_pos++;
			return;
		end
		if (wd.drain)
			return;
		old_mid = middle_line[col_pos];
		up      = upper_line[col_pos];
		win_left   = win_centre;
		win_centre = old_mid;
		win_right  = (col_pos + 1 < LINE_MAX) ? middle_line[col_pos + 1] : '0;
		upper_line[col_pos]  = old_mid;
		middle_line[col_pos] = wd.pix;
		if (row_pos != 0) begin
			acc = 0;
			if (row_pos != 1 && col_pos != 0 && !last_col) begin
				acc = CENTRE_GAIN * int'(win_centre) - int'(win_left) - int'(win_right)
					- int'(up) - int'(wd.pix);
				if (acc < 0)
					acc = 0;
				if (acc > PIX_MAX)
					acc = PIX_MAX;
			end
			sharp_q.push_back('{pix: acc[PIX_W-1:0], eor: last_col, eof: 1'b0});
		end
		if (last_col) begin
			col_pos = 0;
			row_pos++;
		end else
			col_pos++;
	endfunction

	task automatic log_mismatch(string what, logic [7:0] got, logic [7:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
	endtask

	// input side: prediction on every accepted word
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sharpen_predict(cur_word);
		s_went_in <= arst_n && s_axis_tvalid && s_axis_tready;
	end

	always @(negedge clk) begin
		if (s_went_in || !s_axis_tvalid) begin
			if (pix_q.size() != 0 && !(pix_q[0].hold && sharp_q.size() != 0)
					&& $urandom_range(99) >= snd_idle) begin
				cur_word = pix_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= cur_word.pix;
				s_axis_tuser  <= cur_word.drain;
			end else
				s_axis_tvalid <= 1'b0;
		end
		m_axis_tready <= ($urandom_range(99) >= rcv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (sharp_q.size() == 0)
				log_mismatch("output word with nothing due", m_axis_tdata, '0);
			else begin
				due_word = sharp_q.pop_front();
				if (m_axis_tdata !== due_word.pix)
					log_mismatch("out_pixel", m_axis_tdata, due_word.pix);
				if (m_axis_tlast !== due_word.eor)
					log_mismatch("end_of_row", m_axis_tlast, due_word.eor);
				if (m_axis_tuser !== due_word.eof)
					log_mismatch("end_of_frame", m_axis_tuser, due_word.eof);
			end
		end
	end

	task automatic settle();
		while (pix_q.size() != 0 || s_axis_tvalid || sharp_q.size() != 0)
			@(posedge clk);
		// ignored words may still be in the pipeline
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_FRAME_WIDTH)
			geo_width = val[WIDTH_W-1:0];
		else
			geo_height = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic reconfigure(logic [CFG_DATA_W-1:0] w_raw, logic [CFG_DATA_W-1:0] h_raw);
		settle();
		write_reg(REG_FRAME_WIDTH, w_raw);
		write_reg(REG_FRAME_HEIGHT, h_raw);
	endtask

	task automatic push_word(logic [PIX_W-1:0] pix, logic drain, logic hold);
		pix_q.push_back('{pix: pix, drain: drain, hold: hold});
	endtask

	function automatic logic [PIX_W-1:0] rand_pix();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(PIX_MAX));
		endcase
	endfunction

	// one frame plus its flush row; flat frames give mostly unsaturated results
	task automatic push_frame(int unsigned w, int unsigned h, bit flat);
		for (int unsigned r = 0; r < h; r++)
			for (int unsigned c = 0; c < w; c++) begin
				if ($urandom_range(39) == 0)
					push_word(PIX_W'($urandom), 1'b1, 1'b0);  // early flush word, ignored
				push_word(flat ? PIX_W'($urandom_range(90, 130)) : rand_pix(), 1'b0,
					$urandom_range(299) == 0);
				fed++;
			end
		for (int unsigned c = 0; c < w; c++) begin
			push_word(PIX_W'($urandom), $urandom_range(7) != 0, 1'b0);
			fed++;
		end
	endtask

	task automatic random_frames(int unsigned target);
		logic [CFG_DATA_W-1:0] w_raw;
		logic [CFG_DATA_W-1:0] h_raw;
		while (fed < target) begin
			if ($urandom_range(9) < 6) begin
				case ($urandom_range(9))
					0: w_raw = CFG_DATA_W'($urandom_range(2));
					1: w_raw = {4'($urandom_range(1, 15)), 12'($urandom_range(3, 12))};
					default: w_raw = CFG_DATA_W'($urandom_range(3, 16));
				endcase
				h_raw = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(2))
					: CFG_DATA_W'($urandom_range(3, 8));
				reconfigure(w_raw, h_raw);
			end
			push_frame(eff_w(geo_width), eff_h(geo_height), $urandom_range(3) == 0);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// small frame: saturation both ways, early flush word, pixel in the flush row
		reconfigure(4, 4);
		foreach (grid[i]) begin
			if (i == 4)
				push_word(8'hAA, 1'b1, 1'b0);
			push_word(grid[i], 1'b0, i == 9);
		end
		push_word(8'h55, 1'b1, 1'b0);
		push_word(8'h81, 1'b0, 1'b0);
		push_word(8'h00, 1'b1, 1'b0);
		push_word(8'h7E, 1'b1, 1'b0);

		// geometry shrinks mid-frame, past the new last column and row
		reconfigure(5, 5);
		for (int i = 0; i < 18; i++)
			push_word(rand_pix(), 1'b0, 1'b0);
		settle();
		write_reg(REG_FRAME_WIDTH, 3);
		write_reg(REG_FRAME_HEIGHT, 3);
		push_word(rand_pix(), 1'b0, 1'b0);
		repeat (3) push_word(8'hC3, 1'b1, 1'b0);

		random_frames(160);
		settle();
		snd_idle = 53;
		rcv_idle = 9;
		random_frames(320);
		settle();
		snd_idle = 0;
		rcv_idle = 0;
		random_frames(420);

		// tallest frame height: rows keep counting with no early flush
		reconfigure(3, 16'hFFFF);
		for (int r = 0; r < 20; r++)
			repeat (3) push_word(rand_pix(), 1'b0, 1'b0);
		settle();

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
